### rtl/pra_pkg.sv
// Package for the program request arbiter: command, action and mode codes,
// plus the request and result structs shared by the datapath modules.
// No dependencies.
`default_nettype none

package pra_pkg;

  localparam int unsigned CODE_W = 3;

  typedef logic [CODE_W-1:0] code_t;

  // Command codes carried by an input request
  localparam code_t CMD_REFRESH   = 3'd0;
  localparam code_t CMD_EMERGENCY = 3'd1;
  localparam code_t CMD_ABORT     = 3'd2;
  localparam code_t CMD_STOP      = 3'd3;
  localparam code_t CMD_START     = 3'd4;
  localparam code_t CMD_BACKEND   = 3'd5;

  // Action codes returned with each result
  localparam code_t ACT_NONE      = 3'd0;
  localparam code_t ACT_ESTOP     = 3'd1;
  localparam code_t ACT_ABORT     = 3'd2;
  localparam code_t ACT_STOP      = 3'd3;
  localparam code_t ACT_START     = 3'd4;
  localparam code_t ACT_BACKEND   = 3'd5;

  typedef enum logic [CODE_W-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_STARTING  = 3'd1,
    MODE_RUNNING   = 3'd2,
    MODE_STOPPING  = 3'd3,
    MODE_FAULT     = 3'd4,
    MODE_EMERGENCY = 3'd5
  } mode_t;

  typedef struct packed {
    code_t cmd;
    logic  fault;
    logic  active;
    logic  held;
  } req_t;

  typedef struct packed {
    code_t act;
    mode_t mode;
    logic  latch;
  } res_t;

  typedef struct packed {
    mode_t mode;
    logic  latch;
  } stat_t;

endpackage

`default_nettype wire

### rtl/pra_in_if.sv
// Request channel of the program request arbiter: valid/ready plus payload.
// Depends on pra_pkg for the code width.
`default_nettype none

interface pra_in_if;
  import pra_pkg::*;

  logic        valid;
  logic        ready;
  code_t       command;
  logic        fault_now;
  logic        program_running;
  logic        executor_held;

  modport source (output valid, command, fault_now, program_running, executor_held,
                  input ready);
  modport sink   (input valid, command, fault_now, program_running, executor_held,
                  output ready);
endinterface

`default_nettype wire

### rtl/pra_out_if.sv
// Result channel of the program request arbiter: valid/ready plus payload.
// Depends on pra_pkg for the code width.
`default_nettype none

interface pra_out_if;
  import pra_pkg::*;

  logic        valid;
  logic        ready;
  code_t       action;
  code_t       control_state;
  logic        emergency_flag;

  modport source (output valid, action, control_state, emergency_flag, input ready);
  modport sink   (input valid, action, control_state, emergency_flag, output ready);
endinterface

`default_nettype wire

### rtl/program_request_arbiter_top.sv
// Flow: an accepted request is captured in the input register, then its result in the result
// register, which loads when free or draining. Throughput: one request per cycle if results
// drain; a stalled result still lets the input register fill.
// Reset (synchronous, rst_n low): mode goes idle, emergency latch clears, both stages empty.
// The emergency latch clears only on reset.
// Depends on pra_pkg, pra_in_if, pra_out_if and pra_ctrl.
`default_nettype none

module program_request_arbiter_top (
  input  logic      clk,
  input  logic      rst_n,
  pra_in_if.sink    in_req,
  pra_out_if.source out_rsp
);
  import pra_pkg::*;

  logic  in_v_r;
  req_t  in_req_r;
  logic  out_v_r;
  res_t  out_res_r;
  logic  adv;
  res_t  res;
  stat_t cur;

  // Move a request forward when the result register is free or drains this cycle
  assign adv          = in_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_req.ready) in_v_r <= in_req.valid;
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      in_req_r.cmd    <= in_req.command;
      in_req_r.fault  <= in_req.fault_now;
      in_req_r.active <= in_req.program_running;
      in_req_r.held   <= in_req.executor_held;
    end
    if (adv) out_res_r <= res;
  end

  pra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .req   (in_req_r),
    .res   (res),
    .cur   (cur)
  );

  assign out_rsp.valid          = out_v_r;
  assign out_rsp.action         = out_res_r.act;
  assign out_rsp.control_state  = out_res_r.mode;
  assign out_rsp.emergency_flag = out_res_r.latch;

  a_latch_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    cur.latch |=> cur.latch)
    else $error("emergency latch cleared without reset");

  a_estop_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_req_r.cmd == CMD_EMERGENCY) |=>
      (cur.latch && cur.mode == MODE_EMERGENCY && out_v_r && out_res_r.act == ACT_ESTOP))
    else $error("emergency request did not latch and stop");

  a_result_matches_state : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_v_r && out_res_r.mode == cur.mode && out_res_r.latch == cur.latch))
    else $error("result register disagrees with control state");

endmodule

`default_nettype wire

### rtl/pra_decide.sv
// Next-mode and action logic for one request against the current mode and latch.
// Purely combinational; depends on pra_pkg.
`default_nettype none

module pra_decide (
  input  pra_pkg::req_t  req,
  input  pra_pkg::stat_t cur,
  output pra_pkg::res_t  res
);
  import pra_pkg::*;

  logic  blocked;
  logic  halt_ok;
  logic  start_ok;
  mode_t mode_nxt;
  code_t act;

  assign blocked  = cur.latch | req.fault;
  // Halt acts on a live or pending program, but never twice while stopping
  assign halt_ok  = !blocked && (cur.mode != MODE_STOPPING) &&
                    ((cur.mode inside {MODE_STARTING, MODE_RUNNING}) || req.active);
  assign start_ok = !blocked && !req.held && !req.active &&
                    !(cur.mode inside {MODE_STARTING, MODE_STOPPING, MODE_RUNNING});

  always_comb begin
    mode_nxt = cur.mode;
    case (req.cmd)
      CMD_REFRESH: begin
        if (cur.latch) begin
          mode_nxt = MODE_EMERGENCY;
        end else if (req.fault) begin
          mode_nxt = MODE_FAULT;
        end else if (req.active) begin
          mode_nxt = MODE_RUNNING;
        end else if (cur.mode inside {MODE_STARTING, MODE_STOPPING}) begin
          mode_nxt = MODE_IDLE;
        end
      end
      CMD_EMERGENCY: mode_nxt = MODE_EMERGENCY;
      CMD_ABORT, CMD_STOP: begin
        if (halt_ok) mode_nxt = MODE_STOPPING;
      end
      CMD_START: begin
        if (start_ok) mode_nxt = MODE_STARTING;
      end
      default: mode_nxt = cur.mode;
    endcase
  end

  always_comb begin
    act = ACT_NONE;
    case (req.cmd)
      CMD_EMERGENCY: act = ACT_ESTOP;
      CMD_ABORT:     act = halt_ok  ? ACT_ABORT   : ACT_NONE;
      CMD_STOP:      act = halt_ok  ? ACT_STOP    : ACT_NONE;
      CMD_START:     act = start_ok ? ACT_START   : ACT_NONE;
      CMD_BACKEND:   act = blocked  ? ACT_NONE    : ACT_BACKEND;
      default:       act = ACT_NONE;
    endcase
  end

  assign res.act   = act;
  assign res.mode  = mode_nxt;
  assign res.latch = cur.latch | (req.cmd == CMD_EMERGENCY);

endmodule

`default_nettype wire

### rtl/pra_ctrl.sv
// Control state of the arbiter: mode register and sticky emergency latch.
// Instantiates pra_decide; depends on pra_pkg.
`default_nettype none

module pra_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  pra_pkg::req_t  req,
  output pra_pkg::res_t  res,
  output pra_pkg::stat_t cur
);
  import pra_pkg::*;

  mode_t mode_r;
  logic  latch_r;

  assign cur.mode  = mode_r;
  assign cur.latch = latch_r;

  pra_decide u_decide (
    .req (req),
    .cur (cur),
    .res (res)
  );

  // Advance the state only when the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      latch_r <= 1'b0;
    end else if (step) begin
      mode_r  <= res.mode;
      latch_r <= res.latch;
    end
  end

endmodule

`default_nettype wire
